### rtl/rainbow_test_pattern_generator_defines.svh
// assertion macros used by the checker file
`ifndef RAINBOW_TEST_PATTERN_GENERATOR_DEFINES_SVH
`define RAINBOW_TEST_PATTERN_GENERATOR_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define RTPG_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define RTPG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rtpg_pkg.sv
// types and constants of the rainbow test pattern generator
`default_nettype none

package rtpg_pkg;

  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int MAX_DIM    = 4096;
  localparam int CH_W       = 8;
  localparam int RGB_W      = 3 * CH_W;
  localparam int FULL       = 255;
  localparam int NUM_W      = 20;
  localparam int DIV_CNT_W  = $clog2(NUM_W);
  localparam int HUE_W      = 3;
  localparam int BANDS      = 6;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_ENABLED = 2'd2
  } reg_idx_e;

  typedef enum logic [HUE_W-1:0] {
    BAND_RED_YEL = 3'd0,
    BAND_YEL_GRN = 3'd1,
    BAND_GRN_CYN = 3'd2,
    BAND_CYN_BLU = 3'd3,
    BAND_BLU_MAG = 3'd4,
    BAND_MAG_RED = 3'd5
  } band_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CR,
    ST_RR,
    ST_HUE,
    ST_OFS,
    ST_MIX
  } back_state_e;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             enabled;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               active;
    logic               last;
  } px_entry_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DIM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
    logic [DIM_W-1:0] rem;
    logic [HUE_W-1:0] qmod6;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/rtpg_ifs.sv
// valid/ready channels for pixel coordinates and colour words
`default_nettype none

interface rtpg_pix_if;
  logic                        valid;
  logic                        ready;
  logic [rtpg_pkg::COORD_W-1:0] pixel_row;
  logic [rtpg_pkg::COORD_W-1:0] pixel_col;

  modport source (output valid, output pixel_row, output pixel_col, input ready);
  modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

interface rtpg_rgb_if;
  logic                       valid;
  logic                       ready;
  logic [rtpg_pkg::RGB_W-1:0] pixel_rgb;
  logic                       frame_end;

  modport source (output valid, output pixel_rgb, output frame_end, input ready);
  modport sink   (input valid, input pixel_rgb, input frame_end, output ready);
endinterface

`default_nettype wire

### rtl/rtpg_front.sv
// front end: accepts coordinates and tags them as in-frame and last pixel
`default_nettype none

module rtpg_front (
  rtpg_pix_if.sink          pix_i,
  input  rtpg_pkg::cfg_t    cfg_i,
  input  logic              full_i,
  output logic              push_o,
  output rtpg_pkg::px_entry_t entry_o
);
  import rtpg_pkg::*;

  logic inside_frame;
  logic at_last;

  assign inside_frame = cfg_i.enabled
                      && ({1'b0, pix_i.pixel_col} < cfg_i.width)
                      && ({1'b0, pix_i.pixel_row} < cfg_i.height);

  assign at_last = ({1'b0, pix_i.pixel_row} == (cfg_i.height - DIM_W'(1)))
                && ({1'b0, pix_i.pixel_col} == (cfg_i.width - DIM_W'(1)));

  assign pix_i.ready = !full_i;
  assign push_o      = pix_i.valid && !full_i;

  always_comb begin
    entry_o.row    = pix_i.pixel_row;
    entry_o.col    = pix_i.pixel_col;
    entry_o.active = inside_frame;
    entry_o.last   = inside_frame && at_last;
  end

endmodule

`default_nettype wire

### rtl/rtpg_fifo.sv
// short queue between front and back end
`default_nettype none

module rtpg_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rtpg_pkg::px_entry_t entry_i,
  input  logic                pop_i,
  output rtpg_pkg::px_entry_t head_o,
  output logic                empty_o,
  output logic                full_o
);
  import rtpg_pkg::*;

  px_entry_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + FIFO_CNT_W'(1);
      2'b01:   cnt_d = cnt_q - FIFO_CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

### rtl/rtpg_div.sv
// radix-2 restoring divider, one quotient bit per cycle, also tracks quotient mod 6
`default_nettype none

module rtpg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtpg_pkg::div_req_t req_i,
  output rtpg_pkg::div_rsp_t rsp_o
);
  import rtpg_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0]     num_q, num_d;
  logic [DIM_W-1:0]     den_q, den_d;
  logic [DIM_W-1:0]     rem_q, rem_d;
  logic [HUE_W-1:0]     qm_q, qm_d;
  logic [DIM_W:0]       trial;
  logic                 ge;
  logic [HUE_W:0]       qm2;

  // shift next numerator bit into the partial remainder
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign qm2   = {qm_q, ge};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    qm_d   = qm_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      qm_d   = '0;
    end else if (busy_q) begin
      rem_d = ge ? DIM_W'(trial - {1'b0, den_q}) : DIM_W'(trial);
      num_d = {num_q[NUM_W-2:0], ge};
      qm_d  = (qm2 >= (HUE_W+1)'(BANDS)) ? HUE_W'(qm2 - (HUE_W+1)'(BANDS)) : HUE_W'(qm2);
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    qm_q  <= qm_d;
  end

  always_comb begin
    rsp_o.done  = done_q;
    rsp_o.quot  = num_q;
    rsp_o.rem   = rem_q;
    rsp_o.qmod6 = qm_q;
  end

endmodule

`default_nettype wire

### rtl/rtpg_back.sv
// back end: ramps and band through the divider, colour mix, output register, scroll offset
`default_nettype none

module rtpg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rtpg_pkg::cfg_t      cfg_i,
  input  rtpg_pkg::px_entry_t head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output rtpg_pkg::div_req_t  div_req_o,
  input  rtpg_pkg::div_rsp_t  div_rsp_i,
  rtpg_rgb_if.source          pix_o
);
  import rtpg_pkg::*;

  back_state_e        state_q, state_d;
  px_entry_t          cur_q;
  logic [CH_W-1:0]    cr_q, rr_q;
  band_e              band_q;
  logic [COORD_W-1:0] ofs_q;
  logic               out_valid_q;
  logic [RGB_W-1:0]   out_rgb_q;
  logic               out_fe_q;

  logic               out_free;
  logic               take;
  logic               done;
  logic [DIM_W-1:0]   row_ofs;
  logic [CH_W-1:0]    bright;
  logic [CH_W-1:0]    ch_r, ch_g, ch_b;
  logic [RGB_W-1:0]   mix_rgb;

  function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] p);
    logic [2*CH_W:0] t;
    t = {1'b0, p} + (2*CH_W+1)'(p[2*CH_W-1:CH_W]) + (2*CH_W+1)'(1);
    return t[2*CH_W-1:CH_W];
  endfunction

  function automatic logic [NUM_W-1:0] times255(input logic [COORD_W-1:0] v);
    return (NUM_W'(v) << CH_W) - NUM_W'(v);
  endfunction

  assign out_free = !out_valid_q || pix_o.ready;
  assign take     = (state_q == ST_IDLE) && !empty_i && (head_i.active || out_free);
  assign pop_o    = take;
  assign done     = div_rsp_i.done;
  assign row_ofs  = {1'b0, cur_q.row} + {1'b0, ofs_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (take && head_i.active) begin
        state_d = ST_CR;
      end
      ST_CR:   if (done) begin
        state_d = ST_RR;
      end
      ST_RR:   if (done) begin
        state_d = ST_HUE;
      end
      ST_HUE:  if (done) begin
        state_d = cur_q.last ? ST_OFS : ST_MIX;
      end
      ST_OFS:  if (done) begin
        state_d = ST_MIX;
      end
      ST_MIX:  if (out_free) begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // divider requests
  always_comb begin
    div_req_o.start = 1'b0;
    div_req_o.num   = '0;
    div_req_o.den   = cfg_i.height;
    case (state_q)
      ST_IDLE: begin
        div_req_o.start = take && head_i.active;
        div_req_o.num   = times255(head_i.col);
        div_req_o.den   = cfg_i.width;
      end
      ST_CR: begin
        div_req_o.start = done;
        div_req_o.num   = times255(cur_q.row);
      end
      ST_RR: begin
        div_req_o.start = done;
        div_req_o.num   = (NUM_W'(row_ofs) << 2) + (NUM_W'(row_ofs) << 1);
      end
      ST_HUE: begin
        div_req_o.start = done && cur_q.last;
        div_req_o.num   = NUM_W'(ofs_q) + NUM_W'(1);
      end
      default: begin
        div_req_o.start = 1'b0;
      end
    endcase
  end

  // band selection and fade
  always_comb begin
    logic [CH_W-1:0] r, g, b;
    r = '0;
    g = '0;
    b = '0;
    case (band_q)
      BAND_RED_YEL: begin r = CH_W'(FULL); g = cr_q;        b = '0;          end
      BAND_YEL_GRN: begin r = rr_q;        g = CH_W'(FULL); b = '0;          end
      BAND_GRN_CYN: begin r = '0;          g = CH_W'(FULL); b = cr_q;        end
      BAND_CYN_BLU: begin r = '0;          g = rr_q;        b = CH_W'(FULL); end
      BAND_BLU_MAG: begin r = cr_q;        g = '0;          b = CH_W'(FULL); end
      default:      begin r = CH_W'(FULL); g = '0;          b = rr_q;        end
    endcase
    bright  = CH_W'(FULL) - cr_q;
    ch_r    = div255((2*CH_W)'(r) * (2*CH_W)'(bright));
    ch_g    = div255((2*CH_W)'(g) * (2*CH_W)'(bright));
    ch_b    = div255((2*CH_W)'(b) * (2*CH_W)'(bright));
    mix_rgb = {ch_r, ch_g, ch_b};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ofs_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OFS && done) begin
        ofs_q <= div_rsp_i.rem[COORD_W-1:0];
      end
      if ((take && !head_i.active) || (state_q == ST_MIX && out_free)) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q <= head_i;
    end
    if (state_q == ST_CR && done) begin
      cr_q <= div_rsp_i.quot[CH_W-1:0];
    end
    if (state_q == ST_RR && done) begin
      rr_q <= CH_W'(FULL) - div_rsp_i.quot[CH_W-1:0];
    end
    if (state_q == ST_HUE && done) begin
      band_q <= band_e'(div_rsp_i.qmod6);
    end
    if (take && !head_i.active) begin
      out_rgb_q <= '0;
      out_fe_q  <= 1'b0;
    end else if (state_q == ST_MIX && out_free) begin
      out_rgb_q <= mix_rgb;
      out_fe_q  <= cur_q.last;
    end
  end

  assign pix_o.valid     = out_valid_q;
  assign pix_o.pixel_rgb = out_rgb_q;
  assign pix_o.frame_end = out_fe_q;

endmodule

`default_nettype wire

### rtl/rainbow_test_pattern_generator.sv
// Rainbow test pattern generator, top level.
// pix_in_i takes one pixel coordinate (pixel_row, pixel_col) per beat; pix_out_o
// returns one beat per coordinate, in order: pixel_rgb (red 23:16, green 15:8,
// blue 7:0) and frame_end, set on the last pixel of the frame.
// The APB port holds the column count (0x0), the row count (0x4) and the enable
// bit (0x8); write it only while no pixel is in flight.
// A coordinate in the frame passes through one shared divider, which yields one
// quotient bit per cycle and runs three 20-bit divisions (four on the last pixel,
// for the scroll update). The back end takes the next coordinate only once the
// current one has been passed to the output register.
// A black pixel (disabled or outside the frame) skips the divider and goes from
// the queue straight into the output register when the back end is idle.
// A two-entry queue between front and back end keeps accepting while the back
// end computes; the output register holds its beat while the receiver stalls,
// and the queue fills and drops ready when stalls last.
// Reset clears the queue, the output valid flag and the scroll offset, and sets
// 640 x 480, disabled.
`default_nettype none

module rainbow_test_pattern_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rtpg_pix_if.sink                        pix_in_i,
  rtpg_rgb_if.source                      pix_out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rtpg_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rtpg_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rtpg_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import rtpg_pkg::*;

  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;
  logic             enabled_q;
  logic             wr_en;
  reg_idx_e         reg_idx;
  cfg_t             cfg;

  logic             push;
  px_entry_t        entry;
  px_entry_t        head;
  logic             empty;
  logic             full;
  logic             pop;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= DIM_W'(640);
      height_q  <= DIM_W'(480);
      enabled_q <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WIDTH:   width_q   <= pwdata[DIM_W-1:0];
        REG_HEIGHT:  height_q  <= pwdata[DIM_W-1:0];
        REG_ENABLED: enabled_q <= pwdata[0];
        default:     enabled_q <= enabled_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_WIDTH:   prdata = APB_DATA_W'(width_q);
      REG_HEIGHT:  prdata = APB_DATA_W'(height_q);
      REG_ENABLED: prdata = APB_DATA_W'(enabled_q);
      default:     prdata = '0;
    endcase
  end

  // dimensions saturate at the largest frame
  always_comb begin
    cfg.width   = (width_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_q;
    cfg.height  = (height_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_q;
    cfg.enabled = enabled_q;
  end

  rtpg_front u_front (
    .pix_i   (pix_in_i),
    .cfg_i   (cfg),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  rtpg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  rtpg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rtpg_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .head_i    (head),
    .empty_i   (empty),
    .pop_o     (pop),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp),
    .pix_o     (pix_out_o)
  );

endmodule

`default_nettype wire

### rtl/rtpg_checker.sv
// port-level checks for the rainbow test pattern generator, bound to the top level
`default_nettype none
`include "rainbow_test_pattern_generator_defines.svh"

module rtpg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [rtpg_pkg::RGB_W-1:0]    out_rgb_i,
  input logic                          out_frame_end_i,
  input logic                          pready_i
);
  import rtpg_pkg::*;

  // a stalled beat keeps its payload
  `RTPG_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_rgb_i) && $stable(out_frame_end_i), "output beat changed while stalled")

  // nothing comes out right after reset
  `RTPG_ASSERT_IMPL(a_reset_quiet, $rose(rst_ni), !out_valid_i, "output beat right after reset")

  // a frame end beat is never directly followed by another one
  `RTPG_ASSERT_NEXT(a_fe_spacing, out_valid_i && out_ready_i && out_frame_end_i, !(out_valid_i && out_frame_end_i), "frame end beats too close")

  // the register port never waits
  `RTPG_ASSERT_IMPL(a_pready, 1'b1, pready_i, "pready dropped")

endmodule

bind rainbow_test_pattern_generator rtpg_checker u_rtpg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (pix_out_o.valid),
  .out_ready_i     (pix_out_o.ready),
  .out_rgb_i       (pix_out_o.pixel_rgb),
  .out_frame_end_i (pix_out_o.frame_end),
  .pready_i        (pready)
);

`default_nettype wire
